// ===== hdl/srec_pkg.sv =====
// ----------------------------------------------------------------------------
// srec_pkg: shared definitions of the sensor record assembler
// Sizes of the slot pool, the sequencer states and the command bundle that
// the sequencer sends to the slot store.
// ----------------------------------------------------------------------------
package srec_pkg;

	localparam int DEVICES          = 4;
	localparam int SLOTS_PER_DEVICE = 8;
	localparam int TOTAL_SLOTS      = DEVICES * SLOTS_PER_DEVICE;

	localparam int SLOT_W = (SLOTS_PER_DEVICE > 1) ? $clog2(SLOTS_PER_DEVICE) : 1;
	localparam int SCAN_W = $clog2(SLOTS_PER_DEVICE + 1);
	localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

	localparam logic [3:0] ALL_PRESENT  = 4'hF;
	localparam logic [7:0] WINDOW_RESET = 8'd3;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FETCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        rd_en;
		addr_t       rd_addr;
		logic        flag_we;
		addr_t       flag_addr;
		logic        flag_used;
		logic [3:0]  flag_present;
		logic        clear_dev;
		logic [1:0]  dev;
		logic        time_we;
		logic [31:0] time_data;
		logic        val_we;
		logic [1:0]  val_mode;
		logic [7:0]  val_data;
	} store_cmd_t;

	typedef struct packed {
		logic       load;
		logic [1:0] device;
	} result_t;

	// Flat slot index of a device's slot.
	function automatic addr_t slot_addr(input logic [1:0] dev, input slot_t slot);
		return ADDR_W'(dev) * ADDR_W'(SLOTS_PER_DEVICE) + ADDR_W'(slot);
	endfunction

endpackage

// ===== hdl/sensor_record_assembler.sv =====
// ----------------------------------------------------------------------------
// sensor_record_assembler: sensor reading to record assembler
// Files timestamped readings into per-device pools of partial records and
// emits each record once all four fields are present.
// ----------------------------------------------------------------------------
// A request carries one reading (battery, temperature, movement or button)
// of one device with its arrival time. The block scans that device's slots
// from slot 0 upward; the reading joins the first used slot whose stamp lies
// closer than match_window to the arrival time, or else takes the first empty
// slot, which it stamps. When no slot qualifies, the whole pool of that device
// is dropped and slot 0 starts over. A field already held keeps its first
// value. A record with all four fields leaves on the output channel and its
// slot is freed. After a request is accepted, the scan reads the device's
// slots in turn until one fits or the whole pool has been read, an update
// step files the reading, and a record that it completes is then fetched
// and waits until the output register is free; the scan is paced by the single
// window compare, which looks at one slot stamp per cycle as the stamp memory
// delivers it. in_ready is high only while the block waits for a request. The
// result sits in an output register, so the next request is taken while a
// record waits to be collected; a second record is held back until the first
// one has gone.
module sensor_record_assembler (
	input  logic        clk,
	input  logic        arst_n,
	// Reading requests.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  device_index,
	input  logic [1:0]  mode,
	input  logic [7:0]  reading_value,
	input  logic [31:0] arrival_time,
	// Completed records.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_device,
	output logic [31:0] record_time,
	output logic [7:0]  battery_level,
	output logic [7:0]  temperature_value,
	output logic [7:0]  movement_value,
	output logic [7:0]  button_value,
	// Match window register.
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0]            window_q;
	logic                  out_valid_q;
	logic [1:0]            rec_dev_q;
	logic [31:0]           rec_time_q;
	logic [3:0][7:0]       rec_values_q;

	srec_pkg::store_cmd_t  cmd;
	srec_pkg::addr_t       probe_addr;
	srec_pkg::result_t     res;
	logic                  probe_used;
	logic [3:0]            probe_present;
	logic [31:0]           rd_time;
	logic [3:0][7:0]       rd_values;
	logic                  out_busy;

	// The user must write the window register only while no request is in flight; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= srec_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// The output register is busy while it holds a record that is not taken
	// in this cycle.
	assign out_busy = out_valid_q && !out_ready;

	srec_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.device_index  (device_index),
		.mode          (mode),
		.reading_value (reading_value),
		.arrival_time  (arrival_time),
		.window        (window_q),
		.out_busy      (out_busy),
		.rd_time       (rd_time),
		.probe_used    (probe_used),
		.probe_present (probe_present),
		.probe_addr    (probe_addr),
		.cmd           (cmd),
		.res           (res)
	);

	srec_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.probe_addr    (probe_addr),
		.probe_used    (probe_used),
		.probe_present (probe_present),
		.rd_time_q     (rd_time),
		.rd_values_q   (rd_values)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The record payload comes straight from the registered memory reads.
	always_ff @(posedge clk) begin
		if (res.load) begin
			rec_dev_q    <= res.device;
			rec_time_q   <= rd_time;
			rec_values_q <= rd_values;
		end
	end

	assign out_valid         = out_valid_q;
	assign record_device     = rec_dev_q;
	assign record_time       = rec_time_q;
	assign battery_level     = rec_values_q[0];
	assign temperature_value = rec_values_q[1];
	assign movement_value    = rec_values_q[2];
	assign button_value      = rec_values_q[3];

endmodule

// ===== hdl/srec_dist.sv =====
// ----------------------------------------------------------------------------
// srec_dist: timestamp window compare
// Tells whether two 32-bit stamps lie closer together than the window.
// ----------------------------------------------------------------------------
module srec_dist (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [7:0]  window,
	output logic        near
);

	logic [31:0] a_minus_b;
	logic [31:0] b_minus_a;
	logic [31:0] distance;

	always_comb begin
		a_minus_b = a - b;
		b_minus_a = b - a;
		distance  = (a >= b) ? a_minus_b : b_minus_a;
		near      = distance < {24'd0, window};
	end

endmodule

// ===== hdl/srec_store.sv =====
// ----------------------------------------------------------------------------
// srec_store: slot pool storage
// Used and present flags per slot in flip-flops, stamps and field bytes in
// memories with registered reads.
// ----------------------------------------------------------------------------
module srec_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srec_pkg::store_cmd_t  cmd,
	input  srec_pkg::addr_t       probe_addr,
	output logic                  probe_used,
	output logic [3:0]            probe_present,
	output logic [31:0]           rd_time_q,
	output logic [3:0][7:0]       rd_values_q
);

	logic [srec_pkg::TOTAL_SLOTS-1:0] slot_used_q;
	logic [3:0]                       slot_present_q [srec_pkg::TOTAL_SLOTS];
	logic [31:0]                      time_mem [srec_pkg::TOTAL_SLOTS];
	logic [3:0][7:0]                  val_mem  [srec_pkg::TOTAL_SLOTS];

	for (genvar i = 0; i < srec_pkg::TOTAL_SLOTS; i++) begin : g_flags
		localparam int DEV_OF = i / srec_pkg::SLOTS_PER_DEVICE;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slot_used_q[i]    <= 1'b0;
				slot_present_q[i] <= 4'd0;
			end else if (cmd.flag_we && (cmd.flag_addr == srec_pkg::addr_t'(i))) begin
				slot_used_q[i]    <= cmd.flag_used;
				slot_present_q[i] <= cmd.flag_present;
			end else if (cmd.clear_dev && (int'(cmd.dev) == DEV_OF)) begin
				slot_used_q[i]    <= 1'b0;
				slot_present_q[i] <= 4'd0;
			end
		end
	end

	assign probe_used    = slot_used_q[probe_addr];
	assign probe_present = slot_present_q[probe_addr];

	always_ff @(posedge clk) begin
		if (cmd.time_we) begin
			time_mem[cmd.flag_addr] <= cmd.time_data;
		end
		if (cmd.val_we) begin
			val_mem[cmd.flag_addr][cmd.val_mode] <= cmd.val_data;
		end
		if (cmd.rd_en) begin
			rd_time_q   <= time_mem[cmd.rd_addr];
			rd_values_q <= val_mem[cmd.rd_addr];
		end
	end

endmodule

// ===== hdl/srec_ctrl.sv =====
// ----------------------------------------------------------------------------
// srec_ctrl: slot scan sequencer
// Takes one request, scans the device's slots through the shared window
// compare, files the reading and fetches a completed record.
// ----------------------------------------------------------------------------
module srec_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            device_index,
	input  logic [1:0]            mode,
	input  logic [7:0]            reading_value,
	input  logic [31:0]           arrival_time,
	input  logic [7:0]            window,
	input  logic                  out_busy,
	input  logic [31:0]           rd_time,
	input  logic                  probe_used,
	input  logic [3:0]            probe_present,
	output srec_pkg::addr_t       probe_addr,
	output srec_pkg::store_cmd_t  cmd,
	output srec_pkg::result_t     res
);

	srec_pkg::state_t state_q, state_d;

	logic [1:0]                   dev_q;
	logic [1:0]                   mode_q;
	logic [7:0]                   val_q;
	logic [31:0]                  time_q;
	logic [srec_pkg::SCAN_W-1:0]  scan_q, scan_d;
	logic                         cmp_vld_q, cmp_vld_d;
	srec_pkg::slot_t              cmp_slot_q, cmp_slot_d;
	srec_pkg::slot_t              slot_k_q, slot_k_d;
	logic                         stamp_q, stamp_d;
	logic                         clear_q, clear_d;

	logic       near;
	logic [3:0] field_bit;
	logic [3:0] eff_present;
	logic       dup;

	srec_dist u_dist (
		.a      (time_q),
		.b      (rd_time),
		.window (window),
		.near   (near)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srec_pkg::ST_IDLE;
			scan_q    <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_q    <= scan_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dev_q  <= device_index;
			mode_q <= mode;
			val_q  <= reading_value;
			time_q <= arrival_time;
		end
		cmp_slot_q <= cmp_slot_d;
		slot_k_q   <= slot_k_d;
		stamp_q    <= stamp_d;
		clear_q    <= clear_d;
	end

	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		cmp_vld_d  = cmp_vld_q;
		cmp_slot_d = cmp_slot_q;
		slot_k_d   = slot_k_q;
		stamp_d    = stamp_q;
		clear_d    = clear_q;
		in_ready   = 1'b0;
		probe_addr = srec_pkg::slot_addr(dev_q, cmp_slot_q);
		cmd        = '0;
		cmd.dev    = dev_q;
		res.load   = 1'b0;
		res.device = dev_q;

		field_bit   = 4'd1 << mode_q;
		eff_present = stamp_q ? 4'd0 : probe_present;
		dup         = (eff_present & field_bit) != 4'd0;

		case (state_q)
			srec_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (int'(device_index) < srec_pkg::DEVICES)) begin
					scan_d    = '0;
					cmp_vld_d = 1'b0;
					state_d   = srec_pkg::ST_SCAN;
				end
			end
			srec_pkg::ST_SCAN: begin
				if (cmp_vld_q && (!probe_used || near)) begin
					slot_k_d  = cmp_slot_q;
					stamp_d   = !probe_used;
					clear_d   = 1'b0;
					cmp_vld_d = 1'b0;
					state_d   = srec_pkg::ST_UPDATE;
				end else if (cmp_vld_q &&
					(cmp_slot_q == srec_pkg::SLOT_W'(srec_pkg::SLOTS_PER_DEVICE - 1))) begin
					// Nothing fits: the pool is dropped and slot 0 restarts it.
					slot_k_d  = '0;
					stamp_d   = 1'b1;
					clear_d   = 1'b1;
					cmp_vld_d = 1'b0;
					state_d   = srec_pkg::ST_UPDATE;
				end else if (scan_q < srec_pkg::SCAN_W'(srec_pkg::SLOTS_PER_DEVICE)) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = srec_pkg::slot_addr(dev_q, scan_q[srec_pkg::SLOT_W-1:0]);
					cmp_vld_d   = 1'b1;
					cmp_slot_d  = scan_q[srec_pkg::SLOT_W-1:0];
					scan_d      = scan_q + 1'b1;
				end else begin
					cmp_vld_d = 1'b0;
				end
			end
			srec_pkg::ST_UPDATE: begin
				probe_addr       = srec_pkg::slot_addr(dev_q, slot_k_q);
				cmd.flag_we      = 1'b1;
				cmd.flag_addr    = probe_addr;
				cmd.flag_used    = 1'b1;
				cmd.flag_present = dup ? eff_present : (eff_present | field_bit);
				cmd.clear_dev    = clear_q;
				cmd.time_we      = stamp_q;
				cmd.time_data    = time_q;
				cmd.val_we       = !dup;
				cmd.val_mode     = mode_q;
				cmd.val_data     = val_q;
				if (!dup && ((eff_present | field_bit) == srec_pkg::ALL_PRESENT)) begin
					state_d = srec_pkg::ST_FETCH;
				end else begin
					state_d = srec_pkg::ST_IDLE;
				end
			end
			srec_pkg::ST_FETCH: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = srec_pkg::slot_addr(dev_q, slot_k_q);
				state_d     = srec_pkg::ST_FINISH;
			end
			srec_pkg::ST_FINISH: begin
				if (!out_busy) begin
					res.load         = 1'b1;
					cmd.flag_we      = 1'b1;
					cmd.flag_addr    = srec_pkg::slot_addr(dev_q, slot_k_q);
					cmd.flag_used    = 1'b0;
					cmd.flag_present = 4'd0;
					state_d          = srec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srec_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/srec_checker.sv =====
// ----------------------------------------------------------------------------
// srec_checker: port level checks of the sensor record assembler
// Watches the handshakes and the request to record timing at the ports.
// ----------------------------------------------------------------------------
module srec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  record_device,
	input logic [31:0] record_time
);

	// A waiting record stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("record dropped before it was taken");

	// A waiting record keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(record_device) && $stable(record_time))
		else $error("record payload changed while stalled");

	// Every accepted request is followed by a scan, so no request follows directly.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during a scan");

	// A record never shows up in the cycle right after a request was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("record appeared without a scan");

endmodule

bind sensor_record_assembler srec_checker u_srec_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression for sensor_record_assembler
// Sends timestamped readings through the request channel, predicts every
// completed record with a model of the per-device slot pools, and checks
// each record leaving the output channel field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

	// Reading kinds, in the order of the mode field.
	typedef enum logic [1:0] {
		KIND_BATTERY,
		KIND_TEMPERATURE,
		KIND_MOVEMENT,
		KIND_BUTTON
	} reading_kind_t;

	// Ways the record receiver can throttle the output channel.
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PATTERN,
		READY_SPARSE
	} ready_style_t;

	// One completed record as it should appear on the output ports.
	typedef struct packed {
		logic [1:0]  device;
		logic [31:0] stamp;
		logic [7:0]  battery;
		logic [7:0]  temperature;
		logic [7:0]  movement;
		logic [7:0]  button;
	} record_t;

	// This margin covers a request still in flight, up to a scan of the whole
	// pool and the fetch of a record that it completes.
	localparam int SETTLE_CYCLES = srec_pkg::SLOTS_PER_DEVICE + 8;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  device_index = '0;
	logic [1:0]  mode = '0;
	logic [7:0]  reading_value = '0;
	logic [31:0] arrival_time = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  record_device;
	logic [31:0] record_time;
	logic [7:0]  battery_level;
	logic [7:0]  temperature_value;
	logic [7:0]  movement_value;
	logic [7:0]  button_value;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	// Mirror of the block's state, kept by the record predictor.
	logic [7:0]  window_setting = srec_pkg::WINDOW_RESET;
	bit          slot_busy [srec_pkg::TOTAL_SLOTS];
	bit [31:0]   slot_stamp [srec_pkg::TOTAL_SLOTS];
	bit [3:0]    slot_have [srec_pkg::TOTAL_SLOTS];
	bit [7:0]    slot_bytes [srec_pkg::TOTAL_SLOTS][4];

	// Records predicted but not yet seen on the output channel, oldest first.
	record_t     pending_records [$];
	int          failures = 0;

	// Sender pacing: bursts of requests separated by random gaps bounded by max_gap.
	int          max_gap = 0;
	int          burst_left = 0;
	bit          offering = 1'b0;

	// Receiver pacing; hold_request asks the receiver for one long stall.
	ready_style_t ready_style = READY_ALWAYS;
	bit           hold_request = 1'b0;
	logic [10:0]  ready_pattern = 11'b101_1001_1101;

	// Per-device plan for the random traffic: a base time around which the
	// next record's readings are placed, and the kinds already sent for it.
	logic [31:0] plan_anchor [srec_pkg::DEVICES];
	logic [3:0]  plan_mask [srec_pkg::DEVICES] = '{default: '0};

	sensor_record_assembler dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.device_index      (device_index),
		.mode              (mode),
		.reading_value     (reading_value),
		.arrival_time      (arrival_time),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.record_device     (record_device),
		.record_time       (record_time),
		.battery_level     (battery_level),
		.temperature_value (temperature_value),
		.movement_value    (movement_value),
		.button_value      (button_value),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Files one reading into the mirrored pool of its device. Returns 1 and the
	// finished record when the reading completes one. The slots are scanned
	// from 0 upward: a used slot whose stamp is closer than the window takes the
	// reading, an empty slot is claimed and stamped, and when neither turns up
	// the device's whole pool is dropped and slot 0 starts over. Note that the
	// distance is the plain unsigned difference, with no wrap-around.
	function automatic bit file_reading(input logic [1:0] dev, input reading_kind_t kind,
			input logic [7:0] value, input logic [31:0] t, output record_t rec);
		int          base;
		int          k;
		bit          placed;
		logic [31:0] distance;
		base = int'(dev) * srec_pkg::SLOTS_PER_DEVICE;
		k = base;
		placed = 1'b0;
		rec = '0;
		for (int s = 0; s < srec_pkg::SLOTS_PER_DEVICE; s++) begin
			if (!placed) begin
				if (slot_busy[base + s]) begin
					distance = (t >= slot_stamp[base + s]) ? t - slot_stamp[base + s]
						: slot_stamp[base + s] - t;
					if (distance < {24'd0, window_setting}) begin
						k = base + s;
						placed = 1'b1;
					end
				end else begin
					slot_busy[base + s] = 1'b1;
					slot_stamp[base + s] = t;
					slot_have[base + s] = '0;
					k = base + s;
					placed = 1'b1;
				end
			end
		end
		if (!placed) begin
			for (int s = 0; s < srec_pkg::SLOTS_PER_DEVICE; s++) begin
				slot_busy[base + s] = 1'b0;
				slot_have[base + s] = '0;
			end
			slot_busy[base] = 1'b1;
			slot_stamp[base] = t;
		end
		// A kind already held keeps its first value; the slot choice above stays.
		if (slot_have[k][kind])
			return 1'b0;
		slot_bytes[k][kind] = value;
		slot_have[k][kind] = 1'b1;
		if (slot_have[k] != srec_pkg::ALL_PRESENT)
			return 1'b0;
		rec.device = dev;
		rec.stamp = slot_stamp[k];
		rec.battery = slot_bytes[k][KIND_BATTERY];
		rec.temperature = slot_bytes[k][KIND_TEMPERATURE];
		rec.movement = slot_bytes[k][KIND_MOVEMENT];
		rec.button = slot_bytes[k][KIND_BUTTON];
		slot_busy[k] = 1'b0;
		slot_have[k] = '0;
		return 1'b1;
	endfunction

	// Lowers the request valid for a gap set by n; a gap of zero leaves it alone.
	task automatic pause_sender(input int n);
		if (n > 0) begin
			if (offering) begin
				in_valid <= 1'b0;
				offering = 1'b0;
			end
			repeat (n) @(posedge clk);
		end
	endtask

	// Offers one reading and waits for the request to be accepted, then runs
	// the predictor on it. Called only at a rising edge, so the payload changes
	// in the same step in which the previous request was taken.
	task automatic offer_reading(input logic [1:0] dev, input reading_kind_t kind,
			input logic [7:0] value, input logic [31:0] t);
		record_t rec;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			pause_sender($urandom_range(0, max_gap));
		end
		burst_left--;
		device_index <= dev;
		mode <= kind;
		reading_value <= value;
		arrival_time <= t;
		in_valid <= 1'b1;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		if (file_reading(dev, kind, value, t, rec))
			pending_records.push_back(rec);
	endtask

	// Stops offering and waits until every predicted record has come out, then
	// lets a request that completes nothing run to its end.
	task automatic wait_drained();
		int waited;
		waited = 0;
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_records.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_records.size() > 0) begin
			$display("%0t: %0d records never arrived", $time, pending_records.size());
			failures += pending_records.size();
			pending_records.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The window register is only written while the block is idle.
	task automatic write_window(input logic [7:0] w);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_setting = w;
	endtask

	// Random traffic. Most readings belong to planned records: each device
	// collects the four kinds within the current window of its anchor, so
	// records really complete. The rest are near misses around the anchor and
	// readings at arbitrary times, which pile up stale slots and push the pools
	// into being cleared.
	task automatic run_mixed_traffic(input int count);
		logic [1:0]  dev;
		logic [7:0]  value;
		logic [31:0] t;
		int          pick;
		int          roll;
		int          span;
		for (int n = 0; n < count; n++) begin
			dev = 2'($urandom_range(0, srec_pkg::DEVICES - 1));
			value = 8'($urandom);
			pick = $urandom_range(0, 3);
			span = (window_setting > 1) ? int'(window_setting) - 1 : 0;
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				while (plan_mask[dev][pick])
					pick = (pick + 1) % 4;
				t = plan_anchor[dev] + 32'($urandom_range(0, span));
				plan_mask[dev][pick] = 1'b1;
				if (plan_mask[dev] == srec_pkg::ALL_PRESENT) begin
					plan_mask[dev] = '0;
					roll = $urandom_range(0, 9);
					if (roll < 5)
						plan_anchor[dev] += 32'(window_setting) + 32'($urandom_range(0, 40));
					else if (roll < 9)
						plan_anchor[dev] = $urandom;
				end
			end else if (roll < 90) begin
				t = plan_anchor[dev] + 32'($urandom_range(0, 4 * span + 8)) - 32'(2 * span);
			end else begin
				t = $urandom;
			end
			offer_reading(dev, reading_kind_t'(pick), value, t);
		end
	endtask

	// Extremes of every field under the reset window of 3: time zero, the
	// largest time, values 0 and 255, a repeated kind, a distance equal to the
	// window, and a pool that overflows and gets cleared.
	task automatic test_directed();
		ready_style = READY_RANDOM;
		max_gap = 3;
		offer_reading(2'd0, KIND_BATTERY, 8'h00, 32'd0);
		offer_reading(2'd0, KIND_TEMPERATURE, 8'hFF, 32'd0);
		offer_reading(2'd0, KIND_MOVEMENT, 8'h5A, 32'd0);
		offer_reading(2'd0, KIND_BUTTON, 8'hA5, 32'd0);
		offer_reading(2'd3, KIND_BUTTON, 8'hFF, 32'hFFFF_FFFF);
		offer_reading(2'd3, KIND_MOVEMENT, 8'h00, 32'hFFFF_FFFE);
		offer_reading(2'd3, KIND_TEMPERATURE, 8'hFF, 32'hFFFF_FFFD);
		offer_reading(2'd3, KIND_BATTERY, 8'h00, 32'hFFFF_FFFF);
		// The second battery reading must be dropped in favor of the first.
		offer_reading(2'd1, KIND_BATTERY, 8'd10, 32'd100);
		offer_reading(2'd1, KIND_BATTERY, 8'd20, 32'd101);
		offer_reading(2'd1, KIND_TEMPERATURE, 8'd30, 32'd102);
		offer_reading(2'd1, KIND_MOVEMENT, 8'd40, 32'd98);
		offer_reading(2'd1, KIND_BUTTON, 8'd50, 32'd100);
		// Nine stamps ten apart: the ninth finds no slot and clears the pool.
		for (int i = 0; i < 9; i++)
			offer_reading(2'd2, KIND_BATTERY, 8'(i + 1), 32'(1000 + 10 * i));
		// A distance of exactly the window opens a new slot; one less joins.
		offer_reading(2'd2, KIND_TEMPERATURE, 8'h11, 32'd1083);
		offer_reading(2'd2, KIND_TEMPERATURE, 8'h22, 32'd1082);
		offer_reading(2'd2, KIND_MOVEMENT, 8'h33, 32'd1078);
		offer_reading(2'd2, KIND_BUTTON, 8'h44, 32'd1080);
	endtask

	// A window of zero matches nothing: every reading takes a fresh slot until
	// the pool overflows and starts over, and no record ever completes.
	task automatic test_zero_window();
		ready_style = READY_ALWAYS;
		max_gap = 0;
		write_window(8'd0);
		for (int i = 0; i < 10; i++)
			offer_reading(2'd1, reading_kind_t'(i % 4), 8'($urandom), 32'd500);
	endtask

	// Smallest useful window: only identical stamps meet.
	task automatic test_narrow_window();
		ready_style = READY_PATTERN;
		max_gap = 6;
		write_window(8'd1);
		run_mixed_traffic(180);
	endtask

	// Largest window, with a receiver that is mostly stalled.
	task automatic test_wide_window();
		ready_style = READY_SPARSE;
		max_gap = 10;
		write_window(8'd255);
		run_mixed_traffic(200);
	endtask

	// Four random windows, each with its own receiver and sender pacing.
	task automatic test_random_windows();
		for (int p = 0; p < 4; p++) begin
			ready_style = ready_style_t'(p);
			max_gap = $urandom_range(0, 15);
			write_window(8'($urandom_range(2, 254)));
			run_mixed_traffic(120);
		end
	endtask

	// The receiver stalls for a long stretch while the sender keeps completing
	// records back to back, so the output register fills and the block stops
	// taking requests. Afterward the sender waits for every record to come out.
	task automatic test_backpressure();
		ready_style = READY_ALWAYS;
		max_gap = 0;
		write_window(8'd3);
		hold_request = 1'b1;
		for (int r = 0; r < 10; r++)
			for (int i = 0; i < 4; i++)
				offer_reading(2'(r % 4), reading_kind_t'(i), 8'($urandom),
					32'(5000 + 100 * r));
		wait_drained();
	endtask

	// Back on the reset window with no idling on either side.
	task automatic test_steady_stream();
		ready_style = READY_ALWAYS;
		max_gap = 0;
		write_window(srec_pkg::WINDOW_RESET);
		run_mixed_traffic(150);
	endtask

	// Record receiver. A long stall, when asked for, is counted here.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				ready_pattern <= {ready_pattern[0], ready_pattern[10:1]};
				case (ready_style)
					READY_ALWAYS:  out_ready <= 1'b1;
					READY_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
					READY_PATTERN: out_ready <= ready_pattern[0];
					default:       out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
			failures++;
		end
	endtask

	// Every record taken from the output channel is matched against the oldest
	// prediction. Outputs are read before this edge's updates take effect.
	always @(posedge clk) begin
		record_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_records.size() == 0) begin
				$display("%0t: unexpected record, expected none, actual device %0d time %0h",
					$time, record_device, record_time);
				failures++;
			end else begin
				want = pending_records.pop_front();
				check_field("record_device", 32'(want.device), 32'(record_device));
				check_field("record_time", want.stamp, record_time);
				check_field("battery_level", 32'(want.battery), 32'(battery_level));
				check_field("temperature_value", 32'(want.temperature),
					32'(temperature_value));
				check_field("movement_value", 32'(want.movement), 32'(movement_value));
				check_field("button_value", 32'(want.button), 32'(button_value));
			end
		end
	end

	initial begin
		for (int d = 0; d < srec_pkg::DEVICES; d++)
			plan_anchor[d] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_zero_window();
		test_narrow_window();
		test_wide_window();
		test_random_windows();
		test_backpressure();
		test_steady_stream();
		wait_drained();
		if (failures == 0 && pending_records.size() == 0) begin
			$display("sensor_record_assembler regression: pass");
		end else begin
			$display("sensor_record_assembler regression: fail");
		end
		$finish;
	end

	// A run that hangs is stopped here and reported as a fail.
	initial begin
		#5_000_000;
		$display("sensor_record_assembler regression: fail");
		$finish;
	end

endmodule
